### sv/dfs_maze_carver_macros.svh
// ----------------------------------------------------------------------------
// dfs_maze_carver_macros
// Assertion macros for the maze carver; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_MACROS_SVH
`define DFS_MAZE_CARVER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMC_ASSERT_IMP(lbl, ante, cons, msg)
`define DMC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, constants and direction-order functions of the maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int DIM_W       = 9;  // holds 1..256
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int START_W     = 6;
  localparam int OUT_COORD_W = 6;
  localparam int PERM_W      = 5;
  localparam int DIR_W       = 2;
  localparam int NEXT_W      = 3;  // 0..4

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL   = 2'd3;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd16;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd16;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  localparam logic ACTION_BEGIN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TRY,
    ST_CHECK,
    ST_POP,
    ST_POP_LOAD
  } state_e;

  typedef struct packed {
    logic             inb;
    logic [DIR_W-1:0] dir;
  } nbr_t;

  function automatic logic [PERM_W-1:0] perm_reduce(input logic [PERM_W-1:0] p);
    logic [PERM_W-1:0] r;
    r = (p >= PERM_W'(24)) ? p - PERM_W'(24) : p;
    return r;
  endfunction

  // direction at position pos of lexicographic permutation k of R,D,L,U
  function automatic logic [DIR_W-1:0] perm_dir(input logic [PERM_W-1:0] k,
                                                input logic [1:0]        pos);
    logic [1:0]        i0;
    logic [1:0]        i1;
    logic              i2;
    logic [PERM_W-1:0] sub;
    logic [2:0]        k1;
    logic [1:0]        r1_0, r1_1, r1_2;
    logic [1:0]        r2_0, r2_1;
    logic [1:0]        p1, p2, p3;
    logic [1:0]        res;
    i0   = (k >= PERM_W'(18)) ? 2'd3 : (k >= PERM_W'(12)) ? 2'd2 :
           (k >= PERM_W'(6)) ? 2'd1 : 2'd0;
    sub  = (i0 == 2'd3) ? PERM_W'(18) : (i0 == 2'd2) ? PERM_W'(12) :
           (i0 == 2'd1) ? PERM_W'(6) : PERM_W'(0);
    k1   = 3'(k - sub);
    i1   = k1[2:1];
    i2   = k1[0];
    r1_0 = (i0 == 2'd0) ? 2'd1 : 2'd0;
    r1_1 = (i0 <= 2'd1) ? 2'd2 : 2'd1;
    r1_2 = (i0 <= 2'd2) ? 2'd3 : 2'd2;
    p1   = (i1 == 2'd0) ? r1_0 : (i1 == 2'd1) ? r1_1 : r1_2;
    r2_0 = (i1 == 2'd0) ? r1_1 : r1_0;
    r2_1 = (i1 == 2'd2) ? r1_1 : r1_2;
    p2   = i2 ? r2_1 : r2_0;
    p3   = i2 ? r2_0 : r2_1;
    unique case (pos)
      2'd0: res = i0;
      2'd1: res = p1;
      2'd2: res = p2;
      default: res = p3;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/dmc_nbr_unit.sv
// ----------------------------------------------------------------------------
// dmc_nbr_unit
// Shared neighbor unit: picks the next direction of the top cell and checks
// the neighbor against the grid bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_nbr_unit #(
  parameter int ROW_W = 6,
  parameter int COL_W = 6
) (
  input  wire logic [ROW_W-1:0]          row_i,
  input  wire logic [COL_W-1:0]          col_i,
  input  wire logic [dmc_pkg::PERM_W-1:0] perm_i,
  input  wire logic [1:0]                pos_i,
  input  wire logic [dmc_pkg::DIM_W-1:0]  eff_w_i,
  input  wire logic [dmc_pkg::DIM_W-1:0]  eff_h_i,
  output dmc_pkg::nbr_t                  nbr_o,
  output logic [ROW_W-1:0]               nrow_o,
  output logic [COL_W-1:0]               ncol_o
);

  logic [dmc_pkg::DIR_W-1:0] dir;
  logic [ROW_W:0]            nr;
  logic [COL_W:0]            nc;
  logic                      under;

  always_comb begin
    dir   = dmc_pkg::perm_dir(perm_i, pos_i);
    nr    = {1'b0, row_i};
    nc    = {1'b0, col_i};
    under = 1'b0;
    unique case (dir)
      dmc_pkg::DIR_RIGHT: nc = nc + (COL_W+1)'(1);
      dmc_pkg::DIR_DOWN:  nr = nr + (ROW_W+1)'(1);
      dmc_pkg::DIR_LEFT: begin
        under = (col_i == '0);
        nc    = nc - (COL_W+1)'(1);
      end
      dmc_pkg::DIR_UP: begin
        under = (row_i == '0);
        nr    = nr - (ROW_W+1)'(1);
      end
    endcase
    nbr_o.dir = dir;
    nbr_o.inb = !under && (dmc_pkg::DIM_W'(nr) < eff_h_i) &&
                (dmc_pkg::DIM_W'(nc) < eff_w_i);
    nrow_o    = nr[ROW_W-1:0];
    ncol_o    = nc[COL_W-1:0];
  end

endmodule

`default_nettype wire

### sv/dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// dfs_maze_carver
// Randomized depth-first maze carver (recursive backtracker) with a walk
// stack and a visited map held in on-chip memories.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low; exactly one
// result follows, shown for a single cycle with res_valid_o, and the receiver
// cannot stall it. A begin transaction sweeps the visited map one row per
// cycle and registers its result with the write of the last row. An advance
// transaction walks the top cell's remaining directions through one shared
// neighbor unit: an out-of-grid direction takes only the try step, an in-grid
// direction a visited-map read and then a test, and an exhausted cell an
// end-of-order test, then a pop, then a stack memory read of the cell below if
// any; an advance on an empty stack answers straight from idle. Configuration
// must be written by the user only while idle; the block does not enforce it.
`default_nettype none

`include "dfs_maze_carver_macros.svh"

module dfs_maze_carver #(
  parameter int MAX_WIDTH  = dmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dmc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dmc_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic                             action_i,
  input  wire logic [dmc_pkg::PERM_W-1:0]       perm_i,
  output logic                                  res_valid_o,
  output logic                                  carved_o,
  output logic [dmc_pkg::OUT_COORD_W-1:0]       from_row_o,
  output logic [dmc_pkg::OUT_COORD_W-1:0]       from_col_o,
  output logic [dmc_pkg::DIR_W-1:0]             direction_o,
  output logic                                  done_res_o
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SP_W  = $clog2(CELLS + 1);
  localparam int SA_W  = $clog2(CELLS);
  localparam int ENT_W = ROW_W + COL_W + dmc_pkg::PERM_W + dmc_pkg::NEXT_W;
  localparam int DW    = dmc_pkg::DIM_W;

  // configuration
  logic [dmc_pkg::CFG_W-1:0]   grid_width_q, grid_height_q;
  logic [dmc_pkg::START_W-1:0] start_row_q, start_col_q;
  logic [DW-1:0]               eff_w, eff_h;

  // control
  dmc_pkg::state_e state_q, state_d;
  logic [SP_W-1:0] cnt_q, cnt_d;
  logic            res_valid_q, res_valid_d;

  // datapath
  logic [ROW_W-1:0]             top_row_q, top_row_d;
  logic [COL_W-1:0]             top_col_q, top_col_d;
  logic [dmc_pkg::PERM_W-1:0]   top_perm_q, top_perm_d;
  logic [dmc_pkg::NEXT_W-1:0]   top_next_q, top_next_d;
  logic [dmc_pkg::PERM_W-1:0]   cur_perm_q, cur_perm_d;
  logic [ROW_W-1:0]             nr_q, nr_d;
  logic [COL_W-1:0]             nc_q, nc_d;
  logic [dmc_pkg::DIR_W-1:0]    dir_q, dir_d;
  logic [ROW_W-1:0]             clr_q, clr_d;
  logic [ROW_W-1:0]             st_row_q, st_row_d;
  logic [COL_W-1:0]             st_col_q, st_col_d;

  logic                            carved_q, carved_d;
  logic [dmc_pkg::OUT_COORD_W-1:0] from_row_q, from_row_d;
  logic [dmc_pkg::OUT_COORD_W-1:0] from_col_q, from_col_d;
  logic [dmc_pkg::DIR_W-1:0]       dir_res_q, dir_res_d;
  logic                            done_q, done_d;

  // memories
  logic [MAX_WIDTH-1:0] map_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] map_rdata_q;
  logic                 map_we, map_re;
  logic [ROW_W-1:0]     map_waddr, map_raddr;
  logic [MAX_WIDTH-1:0] map_wdata;

  logic [ENT_W-1:0]     stk_mem [CELLS];
  logic [ENT_W-1:0]     stk_rdata_q;
  logic                 stk_we, stk_re;
  logic [SA_W-1:0]      stk_waddr, stk_raddr;
  logic [ENT_W-1:0]     stk_wdata;

  dmc_pkg::nbr_t        nbr;
  logic [ROW_W-1:0]     nbr_row;
  logic [COL_W-1:0]     nbr_col;

  logic                 accept;
  logic                 st_ok;
  logic                 clr_last;
  logic [SP_W-1:0]      cnt_m1, cnt_m2;
  logic                 visited;

  assign accept   = start_i && (state_q == dmc_pkg::ST_IDLE);
  assign clr_last = (clr_q == ROW_W'(MAX_HEIGHT - 1));
  assign cnt_m1   = cnt_q - SP_W'(1);
  assign cnt_m2   = cnt_q - SP_W'(2);
  assign visited  = map_rdata_q[nc_q];

  always_comb begin
    eff_w = (grid_width_q == '0) ? DW'(1) :
            (DW'(grid_width_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(grid_width_q);
    eff_h = (grid_height_q == '0) ? DW'(1) :
            (DW'(grid_height_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(grid_height_q);
    st_ok = (DW'(start_row_q) < eff_h) && (DW'(start_col_q) < eff_w);
  end

  dmc_nbr_unit #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_nbr (
    .row_i   (top_row_q),
    .col_i   (top_col_q),
    .perm_i  (top_perm_q),
    .pos_i   (top_next_q[1:0]),
    .eff_w_i (eff_w),
    .eff_h_i (eff_h),
    .nbr_o   (nbr),
    .nrow_o  (nbr_row),
    .ncol_o  (nbr_col)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmc_pkg::ST_IDLE: begin
        if (accept) begin
          if (action_i == dmc_pkg::ACTION_BEGIN) begin
            state_d = dmc_pkg::ST_CLEAR;
          end else if (cnt_q != '0) begin
            state_d = dmc_pkg::ST_TRY;
          end
        end
      end
      dmc_pkg::ST_CLEAR: begin
        if (clr_last) state_d = dmc_pkg::ST_IDLE;
      end
      dmc_pkg::ST_TRY: begin
        if (top_next_q[2]) begin
          state_d = dmc_pkg::ST_POP;
        end else if (nbr.inb) begin
          state_d = dmc_pkg::ST_CHECK;
        end
      end
      dmc_pkg::ST_CHECK: begin
        state_d = visited ? dmc_pkg::ST_TRY : dmc_pkg::ST_IDLE;
      end
      dmc_pkg::ST_POP: begin
        state_d = (cnt_q == SP_W'(1)) ? dmc_pkg::ST_IDLE : dmc_pkg::ST_POP_LOAD;
      end
      dmc_pkg::ST_POP_LOAD: state_d = dmc_pkg::ST_TRY;
      default: state_d = dmc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    top_row_d   = top_row_q;
    top_col_d   = top_col_q;
    top_perm_d  = top_perm_q;
    top_next_d  = top_next_q;
    cur_perm_d  = cur_perm_q;
    nr_d        = nr_q;
    nc_d        = nc_q;
    dir_d       = dir_q;
    clr_d       = clr_q;
    st_row_d    = st_row_q;
    st_col_d    = st_col_q;
    carved_d    = carved_q;
    from_row_d  = from_row_q;
    from_col_d  = from_col_q;
    dir_res_d   = dir_res_q;
    done_d      = done_q;
    map_we      = 1'b0;
    map_re      = 1'b0;
    map_waddr   = clr_q;
    map_raddr   = nbr_row;
    map_wdata   = '0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = SA_W'(cnt_m1);
    stk_raddr   = SA_W'(cnt_m2);
    stk_wdata   = {top_row_q, top_col_q, top_perm_q, top_next_q};
    unique case (state_q)
      dmc_pkg::ST_IDLE: begin
        if (accept) begin
          cur_perm_d = dmc_pkg::perm_reduce(perm_i);
          clr_d      = '0;
          st_row_d   = st_ok ? ROW_W'(start_row_q) : '0;
          st_col_d   = st_ok ? COL_W'(start_col_q) : '0;
          if ((action_i != dmc_pkg::ACTION_BEGIN) && (cnt_q == '0)) begin
            res_valid_d = 1'b1;
            carved_d    = 1'b0;
            from_row_d  = '0;
            from_col_d  = '0;
            dir_res_d   = dmc_pkg::DIR_RIGHT;
            done_d      = 1'b1;
          end
        end
      end
      dmc_pkg::ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = (clr_q == st_row_q) ?
                    ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << st_col_q) : '0;
        clr_d     = clr_q + ROW_W'(1);
        if (clr_last) begin
          cnt_d       = SP_W'(1);
          top_row_d   = st_row_q;
          top_col_d   = st_col_q;
          top_perm_d  = cur_perm_q;
          top_next_d  = '0;
          res_valid_d = 1'b1;
          carved_d    = 1'b0;
          from_row_d  = dmc_pkg::OUT_COORD_W'(st_row_q);
          from_col_d  = dmc_pkg::OUT_COORD_W'(st_col_q);
          dir_res_d   = dmc_pkg::DIR_RIGHT;
          done_d      = 1'b0;
        end
      end
      dmc_pkg::ST_TRY: begin
        if (!top_next_q[2]) begin
          top_next_d = top_next_q + dmc_pkg::NEXT_W'(1);
          nr_d       = nbr_row;
          nc_d       = nbr_col;
          dir_d      = nbr.dir;
          map_re     = nbr.inb;
        end
      end
      dmc_pkg::ST_CHECK: begin
        if (!visited) begin
          map_we      = 1'b1;
          map_waddr   = nr_q;
          map_wdata   = map_rdata_q | ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << nc_q);
          res_valid_d = 1'b1;
          carved_d    = 1'b1;
          from_row_d  = dmc_pkg::OUT_COORD_W'(top_row_q);
          from_col_d  = dmc_pkg::OUT_COORD_W'(top_col_q);
          dir_res_d   = dir_q;
          done_d      = 1'b0;
          if (cnt_q != SP_W'(CELLS)) begin
            stk_we     = 1'b1;
            cnt_d      = cnt_q + SP_W'(1);
            top_row_d  = nr_q;
            top_col_d  = nc_q;
            top_perm_d = cur_perm_q;
            top_next_d = '0;
          end
        end
      end
      dmc_pkg::ST_POP: begin
        cnt_d  = cnt_m1;
        stk_re = (cnt_q != SP_W'(1));
        if (cnt_q == SP_W'(1)) begin
          res_valid_d = 1'b1;
          carved_d    = 1'b0;
          from_row_d  = '0;
          from_col_d  = '0;
          dir_res_d   = dmc_pkg::DIR_RIGHT;
          done_d      = 1'b1;
        end
      end
      dmc_pkg::ST_POP_LOAD: begin
        {top_row_d, top_col_d, top_perm_d, top_next_d} = stk_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dmc_pkg::ST_IDLE;
      cnt_q         <= '0;
      res_valid_q   <= 1'b0;
      grid_width_q  <= dmc_pkg::GRID_WIDTH_RST;
      grid_height_q <= dmc_pkg::GRID_HEIGHT_RST;
      start_row_q   <= '0;
      start_col_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dmc_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
          dmc_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
          dmc_pkg::REG_START_ROW:   start_row_q   <= cfg_data_i[dmc_pkg::START_W-1:0];
          dmc_pkg::REG_START_COL:   start_col_q   <= cfg_data_i[dmc_pkg::START_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_row_q  <= top_row_d;
    top_col_q  <= top_col_d;
    top_perm_q <= top_perm_d;
    top_next_q <= top_next_d;
    cur_perm_q <= cur_perm_d;
    nr_q       <= nr_d;
    nc_q       <= nc_d;
    dir_q      <= dir_d;
    clr_q      <= clr_d;
    st_row_q   <= st_row_d;
    st_col_q   <= st_col_d;
    carved_q   <= carved_d;
    from_row_q <= from_row_d;
    from_col_q <= from_col_d;
    dir_res_q  <= dir_res_d;
    done_q     <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign busy_o      = (state_q != dmc_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign carved_o    = carved_q;
  assign from_row_o  = from_row_q;
  assign from_col_o  = from_col_q;
  assign direction_o = dir_res_q;
  assign done_res_o  = done_q;

  `DMC_ASSERT_NXT(a_begin_busy, start_i && !busy_o && (action_i == dmc_pkg::ACTION_BEGIN), busy_o, "begin transaction did not enter clear sweep")
  `DMC_ASSERT_IMP(a_walk_nonempty, (state_q == dmc_pkg::ST_TRY) || (state_q == dmc_pkg::ST_CHECK), cnt_q != '0, "walking with an empty stack")
  `DMC_ASSERT_IMP(a_done_empty, res_valid_q && done_q, cnt_q == '0 && !carved_q, "done reported with cells on the stack")
  `DMC_ASSERT_IMP(a_carve_stack, res_valid_q && carved_q, cnt_q != '0 && !done_q, "carve reported with an empty stack")

endmodule

`default_nettype wire

### verif/tb_dfs_maze_carver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dfs_maze_carver
// Self-checking bench for the depth-first maze carver. A scoreboard class
// keeps its own visited map and walk stack and predicts the single result of
// every transaction. Directed mazes cover the corner cases: an advance with
// no maze, clamped grid sizes, an out-of-grid start cell, permutation
// indexes 24..31 and a grid shrunk mid-walk. Random mazes on mostly small
// grids follow, under three sender idle profiles.
// ----------------------------------------------------------------------------
module tb_dfs_maze_carver;
  import dmc_pkg::*;

  localparam int ITEMS       = 650;
  localparam int QUIET_LIMIT = 200000;

  typedef struct packed {
    logic             carved;
    logic [5:0]       row;
    logic [5:0]       col;
    logic [DIR_W-1:0] dir;
    logic             done;
  } carve_t;

  typedef struct {
    int unsigned r;
    int unsigned c;
    int unsigned order;
    int unsigned tried;
  } cell_t;

  class carve_scoreboard;
    int unsigned grid_w, grid_h, row0, col0;
    bit          seen[DEF_MAX_WIDTH * DEF_MAX_HEIGHT];
    cell_t       walk[$];
    carve_t      due[$];
    int          errors, checked, carves, completions;

    function new();
      grid_w = GRID_WIDTH_RST;
      grid_h = GRID_HEIGHT_RST;
      row0   = 0;
      col0   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      case (idx)
        REG_GRID_WIDTH:  grid_w = v & 32'h7f;
        REG_GRID_HEIGHT: grid_h = v & 32'h7f;
        REG_START_ROW:   row0   = v & 32'h3f;
        default:         col0   = v & 32'h3f;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // pos-th direction of the k-th lexicographic ordering of right,down,left,up
    function logic [DIR_W-1:0] order_dir(int unsigned k, int unsigned pos);
      int unsigned pool[$];
      int unsigned fact[3];
      int unsigned idx, pick;
      pool = '{0, 1, 2, 3};
      fact = '{6, 2, 1};
      k = k % 24;
      pick = 0;
      for (int unsigned i = 0; i <= pos; i++) begin
        idx = 0;
        if (i < 3) begin
          idx = k / fact[i];
          k   = k % fact[i];
        end
        pick = pool[idx];
        pool.delete(idx);
      end
      return DIR_W'(pick);
    endfunction

    function void push_cell(int unsigned r, int unsigned c, int unsigned k);
      cell_t e;
      e.r = r;
      e.c = c;
      e.order = k % 24;
      e.tried = 0;
      seen[r * DEF_MAX_WIDTH + c] = 1'b1;
      walk.push_back(e);
    endfunction

    function carve_t next_carve(logic act, int unsigned k);
      carve_t      res;
      int unsigned w, h, r, c, t;
      int          nr, nc;
      logic [DIR_W-1:0] d;
      res = '0;
      w = clamp_dim(grid_w, DEF_MAX_WIDTH);
      h = clamp_dim(grid_h, DEF_MAX_HEIGHT);
      if (act == ACTION_BEGIN) begin
        r = row0;
        c = col0;
        if (r >= h || c >= w) begin
          r = 0;
          c = 0;
        end
        foreach (seen[i]) seen[i] = 1'b0;
        walk.delete();
        push_cell(r, c, k);
        res.row = 6'(r);
        res.col = 6'(c);
        return res;
      end
      while (walk.size() > 0) begin
        t = walk.size() - 1;
        r = walk[t].r;
        c = walk[t].c;
        while (walk[t].tried < 4) begin
          d = order_dir(walk[t].order, walk[t].tried);
          walk[t].tried++;
          nr = int'(r);
          nc = int'(c);
          case (d)
            DIR_RIGHT: nc++;
            DIR_DOWN:  nr++;
            DIR_LEFT:  nc--;
            default:   nr--;
          endcase
          if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w) &&
              !seen[nr * DEF_MAX_WIDTH + nc]) begin
            push_cell(nr, nc, k);
            res.carved = 1'b1;
            res.row = 6'(r);
            res.col = 6'(c);
            res.dir = d;
            return res;
          end
        end
        void'(walk.pop_back());
      end
      res.done = 1'b1;
      return res;
    endfunction

    function void note_input(logic act, int unsigned k);
      due.push_back(next_carve(act, k));
    endfunction

    function void check_result(carve_t got);
      carve_t exp;
      if (due.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
        return;
      end
      exp = due.pop_front();
      checked++;
      carves += exp.carved;
      completions += exp.done;
      if (got.carved !== exp.carved) begin
        $error("carved: expected %0d, got %0d", exp.carved, got.carved);
        errors++;
      end
      if (got.row !== exp.row) begin
        $error("from_row: expected %0d, got %0d", exp.row, got.row);
        errors++;
      end
      if (got.col !== exp.col) begin
        $error("from_col: expected %0d, got %0d", exp.col, got.col);
        errors++;
      end
      if (got.dir !== exp.dir) begin
        $error("direction: expected %0d, got %0d", exp.dir, got.dir);
        errors++;
      end
      if (got.done !== exp.done) begin
        $error("done_res: expected %0d, got %0d", exp.done, got.done);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i  = REG_GRID_WIDTH;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   start_i    = 1'b0;
  logic                   action_i   = 1'b0;
  logic [PERM_W-1:0]      perm_i     = '0;
  logic                   busy_o;
  logic                   res_valid_o;
  logic                   carved_o;
  logic [OUT_COORD_W-1:0] from_row_o;
  logic [OUT_COORD_W-1:0] from_col_o;
  logic [DIR_W-1:0]       direction_o;
  logic                   done_res_o;

  carve_scoreboard sb = new();
  int              n_sent = 0;
  int              n_settings = 0;
  int              idle_pct = 21;
  int              quiet = 0;

  always #5 clk_i = ~clk_i;

  dfs_maze_carver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .action_i   (action_i),
    .perm_i     (perm_i),
    .res_valid_o(res_valid_o),
    .carved_o   (carved_o),
    .from_row_o (from_row_o),
    .from_col_o (from_col_o),
    .direction_o(direction_o),
    .done_res_o (done_res_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      sb.check_result({carved_o, from_row_o, from_col_o, direction_o, done_res_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || res_valid_o === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(logic act, int unsigned k);
    int gap;
    gap = 0;
    idle_pct = (n_sent < ITEMS / 3) ? 21 : (n_sent < 2 * ITEMS / 3) ? 71 : 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    perm_i   <= PERM_W'(k);
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_input(act, k);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned r, int unsigned c);
    int unsigned vals[4];
    vals = '{w, h, r, c};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= CFG_W'(vals[i]);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(11))
      0:       return 0;
      1:       return 1;
      2:       return 64;
      3:       return $urandom_range(65, 127);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  initial begin
    int unsigned w, h, r, c, cells, steps;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // advance with no maze, then a walk on the reset grid
    send_item(1'b1, 5);
    send_item(ACTION_BEGIN, 31);
    send_item(1'b1, 0);
    send_item(1'b1, 23);
    send_item(1'b1, 24);

    // zero sizes act as a single cell
    set_config(0, 0, 0, 0);
    send_item(ACTION_BEGIN, 3);
    send_item(1'b1, 9);
    send_item(1'b1, 17);

    // oversize width, start cell outside the grid
    set_config(127, 1, 63, 63);
    send_item(ACTION_BEGIN, 12);
    repeat (3) send_item(1'b1, 1);

    // grid shrinks under a walk in progress
    set_config(3, 3, 2, 2);
    send_item(ACTION_BEGIN, 6);
    repeat (3) send_item(1'b1, 30);
    set_config(2, 3, 2, 2);
    repeat (4) send_item(1'b1, $urandom_range(31));

    while (n_sent < ITEMS) begin
      w = pick_dim();
      h = pick_dim();
      if ($urandom_range(1)) begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end else begin
        r = $urandom_range(sb.clamp_dim(h, DEF_MAX_HEIGHT) - 1);
        c = $urandom_range(sb.clamp_dim(w, DEF_MAX_WIDTH) - 1);
      end
      set_config(w, h, r, c);
      cells = sb.clamp_dim(w, DEF_MAX_WIDTH) * sb.clamp_dim(h, DEF_MAX_HEIGHT);
      steps = (cells <= 64) ? 2 * cells + $urandom_range(3) : $urandom_range(20, 60);
      send_item(ACTION_BEGIN, $urandom_range(31));
      for (int unsigned i = 0; i < steps && n_sent < ITEMS; i++) begin
        if (i == steps / 2 && $urandom_range(4) == 0) begin
          set_config($urandom_range(1, 8), $urandom_range(1, 8), r, c);
        end
        if ($urandom_range(39) == 0) begin
          send_item(ACTION_BEGIN, $urandom_range(31));
        end else begin
          send_item(1'b1, $urandom_range(31));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("checked %0d transactions over %0d grid settings", sb.checked, n_settings);
    $display("%0d passages carved, %0d completed-maze responses", sb.carves,
             sb.completions);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
